// ===== design/elimination_tree_builder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// elimination_tree_builder_unit_macros.svh
// Assertion macros shared by the checker of the elimination tree builder.
// ----------------------------------------------------------------------------
`ifndef ELIMINATION_TREE_BUILDER_UNIT_MACROS_SVH
`define ELIMINATION_TREE_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ETB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("etb assertion failed");

// Next-cycle implication, off during reset.
`define ETB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("etb assertion failed");

// Next-cycle implication that also holds across reset.
`define ETB_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("etb assertion failed");

`endif

// ===== design/etb_pkg.sv =====
// ----------------------------------------------------------------------------
// etb_pkg
// Shared constants and types of the elimination tree builder.
// ----------------------------------------------------------------------------
`default_nettype none

package etb_pkg;

   localparam int LABEL_W  = 11;
   localparam int NODES_DEF = 1024;

   // operation codes of an input beat
   localparam logic OP_ROW = 1'b0;
   localparam logic OP_COL = 1'b1;

   // decoded input beat handed to the walker
   typedef struct packed {
      logic start;     // beat accepted this cycle
      logic op;        // OP_ROW or OP_COL
      logic in_range;  // label maps to a valid node index
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/etb_anc_mem.sv =====
// ----------------------------------------------------------------------------
// etb_anc_mem
// Ancestor store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module etb_anc_mem #(
   parameter int DEPTH = etb_pkg::NODES_DEF,
   parameter int AW    = $clog2(etb_pkg::NODES_DEF)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [AW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [AW-1:0] rd_data
);

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/etb_walker.sv =====
// ----------------------------------------------------------------------------
// etb_walker
// Row state and ancestor walk with path compression over the ancestor store.
// ----------------------------------------------------------------------------
`default_nettype none

module etb_walker #(
   parameter int NODES = etb_pkg::NODES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire etb_pkg::cmd_type           cmd,
   input  wire logic [$clog2(NODES)-1:0]   idx,
   output logic                            busy,
   output logic                            mem_wr_en,
   output logic      [$clog2(NODES)-1:0]   mem_wr_addr,
   output logic      [$clog2(NODES)-1:0]   mem_wr_data,
   output logic      [$clog2(NODES)-1:0]   mem_rd_addr,
   input  wire logic [$clog2(NODES)-1:0]   mem_rd_data,
   output logic                            rsp_valid,
   output logic      [$clog2(NODES)-1:0]   child_idx,
   output logic      [$clog2(NODES)-1:0]   parent_idx
);

   localparam int AW = $clog2(NODES);
   localparam int SW = $clog2(NODES + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic          state_ff, state_in;
   logic [AW-1:0] row_ff, row_in;
   logic          closed_ff, closed_in;
   logic [AW-1:0] node_ff, node_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic          valid_ff, valid_in;
   logic [AW-1:0] child_ff, child_in;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      closed_in   = closed_ff;
      node_in     = node_ff;
      steps_in    = steps_ff;
      valid_in    = 1'b0;
      child_in    = child_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx;
      mem_wr_data = idx;
      mem_rd_addr = idx;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == etb_pkg::OP_ROW) begin
                  if (cmd.in_range) begin
                     row_in    = idx;
                     closed_in = 1'b0;
                     mem_wr_en = 1'b1;
                  end else begin
                     row_in    = '0;
                     closed_in = 1'b1;
                  end
               end else if (!closed_ff && cmd.in_range) begin
                  if (idx >= row_ff) begin
                     closed_in = 1'b1;
                  end else begin
                     node_in  = idx;
                     steps_in = '0;
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            mem_rd_addr = mem_rd_data;
            mem_wr_addr = node_ff;
            mem_wr_data = row_ff;
            if (mem_rd_data == node_ff) begin
               // root reached: link it to the row and report
               mem_wr_en = 1'b1;
               valid_in  = 1'b1;
               child_in  = node_ff;
               state_in  = ST_IDLE;
            end else if (mem_rd_data == row_ff) begin
               state_in = ST_IDLE;
            end else if (steps_ff == SW'(NODES)) begin
               state_in = ST_IDLE;
            end else begin
               // compress and advance
               mem_wr_en = 1'b1;
               node_in   = mem_rd_data;
               steps_in  = steps_ff + SW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         row_ff    <= '0;
         closed_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         closed_ff <= closed_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      steps_ff <= steps_in;
      child_ff <= child_in;
   end

   assign busy       = (state_ff == ST_WALK);
   assign rsp_valid  = valid_ff;
   assign child_idx  = child_ff;
   assign parent_idx = row_ff;

endmodule

`default_nettype wire

// ===== design/elimination_tree_builder_unit.sv =====
// ----------------------------------------------------------------------------
// elimination_tree_builder_unit
// Elimination tree of a sparse symmetric matrix, path-compressed ancestor walk.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_op, req_row_label, req_col_label with start; a
//   beat is taken at a clock edge where start is high and busy is low.
//   A row-start beat (op 0) names the current row; nonzero beats (op 1)
//   carry column labels of that row, in any order.
//   Result channel: rsp_valid marks one cycle holding a link beat
//   (rsp_child_label receives parent rsp_parent_label). The receiver cannot
//   stall; take the beat in that cycle.
//   Config: csr_wr_en/csr_wr_data set the label base; write only when idle.
// Timing:
//   Row-start and ignored nonzero beats leave busy low.
//   A walking nonzero keeps busy high while the ancestor of each node on its
//   path is read (at least one node); the single ancestor store read port
//   advances one node a cycle. A link beat shows on the cycle busy drops.
// Reset: row state, label base and strobe clear; the ancestor store does not.
//   The user must write each entry by its row-start beat before use; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module elimination_tree_builder_unit #(
   parameter int NODES = etb_pkg::NODES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_op,
   input  wire logic [etb_pkg::LABEL_W-1:0] req_row_label,
   input  wire logic [etb_pkg::LABEL_W-1:0] req_col_label,
   output logic                             rsp_valid,
   output logic      [etb_pkg::LABEL_W-1:0] rsp_child_label,
   output logic      [etb_pkg::LABEL_W-1:0] rsp_parent_label,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data
);

   localparam int LW = etb_pkg::LABEL_W;
   localparam int AW = $clog2(NODES);
   // wide enough for labels, indices and NODES itself
   localparam int XW = ((AW > LW) ? AW : LW) + 1;

   logic            base_ff;
   logic [LW-1:0]   label_sel;
   logic [XW-1:0]   label_off;
   logic            label_ok;
   logic [AW-1:0]   node_idx;
   etb_pkg::cmd_type cmd;

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [AW-1:0]   mem_wr_data;
   logic [AW-1:0]   mem_rd_addr;
   logic [AW-1:0]   mem_rd_data;

   logic            link_valid;
   logic [AW-1:0]   child_idx;
   logic [AW-1:0]   parent_idx;
   logic [XW-1:0]   child_sum;
   logic [XW-1:0]   parent_sum;

   // label base register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 1'b0;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   // strip the base and range-check the label the beat uses
   assign label_sel = (req_op == etb_pkg::OP_ROW) ? req_row_label : req_col_label;
   assign label_off = XW'(label_sel) - XW'(base_ff);
   assign label_ok  = (label_sel >= LW'(base_ff)) && (label_off < XW'(NODES));
   assign node_idx  = label_off[AW-1:0];

   assign cmd.start    = start && !busy;
   assign cmd.op       = req_op;
   assign cmd.in_range = label_ok;

   etb_walker #(
      .NODES (NODES)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .idx         (node_idx),
      .busy        (busy),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (link_valid),
      .child_idx   (child_idx),
      .parent_idx  (parent_idx)
   );

   etb_anc_mem #(
      .DEPTH (NODES),
      .AW    (AW)
   ) u_anc_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // put the base back on, wrap to the label width
   assign child_sum  = XW'(child_idx) + XW'(base_ff);
   assign parent_sum = XW'(parent_idx) + XW'(base_ff);

   assign rsp_valid        = link_valid;
   assign rsp_child_label  = child_sum[LW-1:0];
   assign rsp_parent_label = parent_sum[LW-1:0];

endmodule

`default_nettype wire

// ===== design/etb_checker.sv =====
// ----------------------------------------------------------------------------
// etb_checker
// Port-level checks of the elimination tree builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "elimination_tree_builder_unit_macros.svh"

module etb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_op,
   input wire logic rsp_valid
);

   // reset leaves the block idle
   `ETB_ASSERT_ALWAYS_NEXT(a_reset_idle, reset, !busy && !rsp_valid)

   // a link beat appears only as the walk ends
   `ETB_ASSERT_NOW(a_rsp_after_walk, rsp_valid, $past(busy) && !busy)

   // a row-start beat never walks and never reports
   `ETB_ASSERT_NEXT(a_row_quiet, start && !busy && (req_op == etb_pkg::OP_ROW),
      !busy && !rsp_valid)

   // at most one link beat per item
   `ETB_ASSERT_NEXT(a_single_rsp, rsp_valid, !rsp_valid)

endmodule

bind elimination_tree_builder_unit etb_checker u_etb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_op    (req_op),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

// ===== tb/elimination_tree_builder_unit_test.sv =====
// ----------------------------------------------------------------------------
// elimination_tree_builder_unit_test
// Self-checking bench for the elimination tree builder: streams row-start and
// nonzero beats, mirrors the ancestor walk with path compression, and checks
// every emitted link beat in order against the mirrored tree.
// ----------------------------------------------------------------------------

module elimination_tree_builder_unit_test;

   localparam int LABEL_W    = etb_pkg::LABEL_W;
   localparam int NODE_COUNT = etb_pkg::NODES_DEF;
   localparam int MAX_LABEL  = 1024;

   typedef struct packed {
      logic               op;
      logic [LABEL_W-1:0] row;
      logic [LABEL_W-1:0] col;
   } entry_beat_type;

   typedef struct packed {
      logic [LABEL_W-1:0] child;
      logic [LABEL_W-1:0] parent;
   } link_beat_type;

   // DUT ports; every input starts at a known value
   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               start         = 1'b0;
   logic               req_op        = etb_pkg::OP_ROW;
   logic [LABEL_W-1:0] req_row_label = '0;
   logic [LABEL_W-1:0] req_col_label = '0;
   logic               csr_wr_en     = 1'b0;
   logic               csr_wr_data   = 1'b0;
   logic               busy;
   logic               rsp_valid;
   logic [LABEL_W-1:0] rsp_child_label;
   logic [LABEL_W-1:0] rsp_parent_label;

   elimination_tree_builder_unit #(.NODES(NODE_COUNT)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_row_label   (req_row_label),
      .req_col_label   (req_col_label),
      .rsp_valid       (rsp_valid),
      .rsp_child_label (rsp_child_label),
      .rsp_parent_label(rsp_parent_label),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #4 clock = ~clock;

   // --------------------------------------------------------------------------
   // Shared bench state
   // --------------------------------------------------------------------------
   entry_beat_type beats_to_send[$];  // stimulus not yet offered
   link_beat_type  links_due[$];      // links predicted but not yet seen

   // tree mirror, advanced at each accepted beat
   logic [LABEL_W-1:0] anc_of [NODE_COUNT];
   int                 tree_row    = 0;
   bit                 tree_closed = 1'b0;
   int                 tree_base   = 0;

   // generator view of the same tree: which nodes hold a written ancestor
   bit started [NODE_COUNT];
   int gen_row    = 0;
   bit gen_closed = 1'b0;
   int gen_base   = 0;
   int queued_beats = 0;   // beats queued so far

   bit beat_taken  = 1'b0;
   bit quiet       = 1'b0;  // no sender idling in the closing phase
   bit drain_hold  = 1'b0;
   int gap_left    = 0;
   int sent_count  = 0;
   int row_starts  = 0;
   int links_seen  = 0;
   int error_count = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 30)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // --------------------------------------------------------------------------
   // Tree predictor: apply one beat, return 1 and the link when a root is hung
   // under the current row.
   // --------------------------------------------------------------------------
   function automatic bit link_from_beat(input logic op, input int row_lbl,
                                         input int col_lbl,
                                         output logic [LABEL_W-1:0] child,
                                         output logic [LABEL_W-1:0] parent);
      int j;
      int up;
      int steps;
      bit walking;
      child  = '0;
      parent = '0;
      if (op == etb_pkg::OP_ROW) begin
         // out-of-range row: close it, touch no entry
         if (row_lbl < tree_base || row_lbl - tree_base >= NODE_COUNT) begin
            tree_row    = 0;
            tree_closed = 1'b1;
         end else begin
            tree_row         = row_lbl - tree_base;
            tree_closed      = 1'b0;
            anc_of[tree_row] = tree_row[LABEL_W-1:0];
         end
         return 1'b0;
      end
      if (tree_closed)
         return 1'b0;
      // out-of-range column: drop this beat alone
      if (col_lbl < tree_base || col_lbl - tree_base >= NODE_COUNT)
         return 1'b0;
      j = col_lbl - tree_base;
      if (j >= tree_row) begin
         tree_closed = 1'b1;
         return 1'b0;
      end
      // climb toward a root, pointing each visited node at the current row
      steps   = 0;
      walking = 1'b1;
      while (walking) begin
         up = int'(anc_of[j]);
         if (up == j || up == tree_row)
            walking = 1'b0;
         else begin
            if (steps >= NODE_COUNT)
               return 1'b0;
            steps++;
            anc_of[j] = tree_row[LABEL_W-1:0];
            if (up >= NODE_COUNT)
               return 1'b0;
            j = up;
         end
      end
      if (int'(anc_of[j]) == j) begin
         anc_of[j] = tree_row[LABEL_W-1:0];
         child     = LABEL_W'(j + tree_base);
         parent    = LABEL_W'(tree_row + tree_base);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------

   // A column is safe unless it would start a walk at a node never written.
   function automatic bit col_is_safe(input int label);
      int j;
      j = label - gen_base;
      if (gen_closed || label < gen_base || j >= NODE_COUNT)
         return 1'b1;
      return (j >= gen_row) || started[j];
   endfunction

   // Queue one beat; the unused label field carries random bits.
   task automatic queue_beat(input logic op, input int label);
      entry_beat_type b;
      int idx;
      b.op  = op;
      b.row = (op == etb_pkg::OP_ROW) ? LABEL_W'(label)
                                      : LABEL_W'($urandom_range(0, MAX_LABEL));
      b.col = (op == etb_pkg::OP_COL) ? LABEL_W'(label)
                                      : LABEL_W'($urandom_range(0, MAX_LABEL));
      idx   = label - gen_base;
      if (op == etb_pkg::OP_ROW) begin
         if (label < gen_base || idx >= NODE_COUNT) begin
            gen_row    = 0;
            gen_closed = 1'b1;
         end else begin
            gen_row      = idx;
            gen_closed   = 1'b0;
            started[idx] = 1'b1;
         end
      end else if (!gen_closed && label >= gen_base && idx < NODE_COUNT) begin
         if (idx >= gen_row)
            gen_closed = 1'b1;
      end
      queued_beats++;
      beats_to_send = {beats_to_send, b};
   endtask

   // Mostly well-formed matrices (rows in order, columns from earlier rows),
   // the rest noise: stray rows, out-of-range labels, orphan columns.
   task automatic queue_random_part(input int goal);
      int n;
      int first;
      int k;
      int j;
      int lbl;
      goal = queued_beats + goal;
      while (queued_beats < goal) begin
         if ($urandom_range(0, 9) < 8) begin
            n     = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 200)
                                                 : $urandom_range(2, 40);
            first = $urandom_range(0, NODE_COUNT - n);
            for (int r = first; r < first + n; r++) begin
               if (queued_beats >= goal)
                  break;
               queue_beat(etb_pkg::OP_ROW, r + gen_base);
               k = $urandom_range(0, 5);
               for (int t = 0; t < k; t++) begin
                  if (r > first && $urandom_range(0, 3) != 0)
                     j = $urandom_range(first, r - 1);
                  else
                     j = $urandom_range(0, r);
                  lbl = j + gen_base;
                  if ($urandom_range(0, 19) == 0)
                     lbl = (gen_base == 1) ? 0 : MAX_LABEL;
                  if (!col_is_safe(lbl))
                     lbl = r + gen_base;
                  queue_beat(etb_pkg::OP_COL, lbl);
               end
               // diagonal entry closes the row; whatever follows is dropped
               if ($urandom_range(0, 2) == 0) begin
                  queue_beat(etb_pkg::OP_COL, r + gen_base);
                  if ($urandom_range(0, 1) == 0)
                     queue_beat(etb_pkg::OP_COL, $urandom_range(0, MAX_LABEL));
               end
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               lbl = ($urandom_range(0, 7) == 0) ? MAX_LABEL * $urandom_range(0, 1)
                                                 : $urandom_range(0, MAX_LABEL);
               if ($urandom_range(0, 9) < 3)
                  queue_beat(etb_pkg::OP_ROW, lbl);
               else begin
                  if (!col_is_safe(lbl))
                     lbl = gen_row + gen_base;
                  queue_beat(etb_pkg::OP_COL, lbl);
               end
            end
         end
      end
   endtask

   // Hold until every beat is taken and every link has come, then let any
   // walk that emits nothing run out.
   task automatic wait_until_settled();
      do
         @(posedge clock);
      while (beats_to_send.size() != 0 || start || links_due.size() != 0);
      repeat (NODE_COUNT + 16) @(posedge clock);
   endtask

   // Write the label base; only called while the block is idle.
   task automatic write_base(input bit value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      tree_base    = value;
      gen_base     = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // --------------------------------------------------------------------------
   // Driver: offer beats at the falling edge, hold each until it is taken
   // --------------------------------------------------------------------------
   always @(negedge clock) begin : drive_beats
      entry_beat_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !beat_taken) begin
         // hold the offered beat while the block is busy
      end else begin
         beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (drain_hold && links_due.size() != 0) begin
            start <= 1'b0;
         end else if (beats_to_send.size() != 0) begin
            drain_hold = 1'b0;
            nxt        = beats_to_send.pop_front();
            start         <= 1'b1;
            req_op        <= nxt.op;
            req_row_label <= nxt.row;
            req_col_label <= nxt.col;
            sent_count++;
            if (!quiet) begin
               if ($urandom_range(0, 3) == 0)
                  gap_left = $urandom_range(1, 10);
               // now and then, drain every pending link before the next beat
               if (sent_count % 97 == 50 || $urandom_range(0, 59) == 0)
                  drain_hold = 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Acceptance: advance the tree mirror on each beat the block takes
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : take_beats
      logic [LABEL_W-1:0] child;
      logic [LABEL_W-1:0] parent;
      link_beat_type      lnk;
      if (!reset && start && !busy) begin
         beat_taken = 1'b1;
         if (req_op == etb_pkg::OP_ROW)
            row_starts++;
         if (link_from_beat(req_op, int'(req_row_label), int'(req_col_label),
                            child, parent)) begin
            lnk.child  = child;
            lnk.parent = parent;
            links_due  = {links_due, lnk};
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: each link beat must match the oldest predicted link
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : check_links
      link_beat_type want;
      if (!reset && rsp_valid) begin
         if (links_due.size() == 0) begin
            report_mismatch($sformatf("unexpected link %0d -> %0d",
                                      rsp_child_label, rsp_parent_label));
         end else begin
            want = links_due.pop_front();
            links_seen++;
            if (rsp_child_label !== want.child)
               report_mismatch($sformatf("child label %0d, predicted %0d",
                                         rsp_child_label, want.child));
            if (rsp_parent_label !== want.parent)
               report_mismatch($sformatf("parent label %0d, predicted %0d",
                                         rsp_parent_label, want.parent));
         end
      end
   end

   // --------------------------------------------------------------------------
   // Sequence: reset, then three phases across both label bases
   // --------------------------------------------------------------------------
   initial begin : run_phases
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // zero-based labels
      write_base(1'b0);
      queue_beat(etb_pkg::OP_COL, 5);          // entry before any row start closes row 0
      queue_beat(etb_pkg::OP_COL, 0);          // dropped, row closed
      queue_beat(etb_pkg::OP_ROW, 0);
      queue_beat(etb_pkg::OP_ROW, 3);
      queue_beat(etb_pkg::OP_COL, 0);          // root 0 hangs under 3
      queue_beat(etb_pkg::OP_COL, 3);          // diagonal closes the row
      queue_beat(etb_pkg::OP_COL, 1);          // dropped after close
      queue_beat(etb_pkg::OP_ROW, MAX_LABEL);  // row out of range
      queue_beat(etb_pkg::OP_COL, 0);          // dropped, out-of-range row is closed
      queue_beat(etb_pkg::OP_ROW, NODE_COUNT - 1);
      queue_beat(etb_pkg::OP_COL, MAX_LABEL);  // out-of-range column, row stays open
      queue_beat(etb_pkg::OP_COL, 0);          // walk 0 -> 3, root 3 hangs under top row
      queue_beat(etb_pkg::OP_COL, 3);          // already points at the row, no link
      queue_beat(etb_pkg::OP_ROW, 1);          // row out of order
      queue_beat(etb_pkg::OP_COL, 0);          // compressed path leads to a new root
      queue_beat(etb_pkg::OP_COL, 1);
      queue_beat(etb_pkg::OP_ROW, 2);
      queue_beat(etb_pkg::OP_COL, 1);
      queue_beat(etb_pkg::OP_COL, 0);
      wait_until_settled();
      queue_random_part(500);
      wait_until_settled();

      // one-based labels
      write_base(1'b1);
      queue_beat(etb_pkg::OP_ROW, 0);          // below the base: row closed
      queue_beat(etb_pkg::OP_COL, 1);
      queue_beat(etb_pkg::OP_ROW, 1);          // node 0
      queue_beat(etb_pkg::OP_COL, 0);          // below the base: dropped alone
      queue_beat(etb_pkg::OP_COL, 1);          // diagonal
      queue_beat(etb_pkg::OP_ROW, MAX_LABEL);  // top node
      queue_beat(etb_pkg::OP_COL, 1);
      queue_beat(etb_pkg::OP_COL, MAX_LABEL);
      queue_beat(etb_pkg::OP_COL, 2);
      wait_until_settled();
      queue_random_part(500);
      wait_until_settled();

      // back to zero-based, sender runs flat out
      write_base(1'b0);
      quiet = 1'b1;
      queue_random_part(600);
      wait_until_settled();

      $display("run covered %0d beats (%0d row starts) over label bases 0 and 1",
               sent_count, row_starts);
      $display("%0d link beats checked, %0d mismatches", links_seen, error_count);
      if (error_count == 0)
         $display("elimination_tree_builder_unit_test: clean");
      else
         $display("elimination_tree_builder_unit_test: errors");
      $finish;
   end

   // Watchdog: a stuck handshake or a missing link ends the run here.
   initial begin : watchdog
      #64000000;
      $display("timeout waiting for the block");
      $display("elimination_tree_builder_unit_test: errors");
      $finish;
   end

endmodule
